// ===== rtl/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants, control structs and digit helpers for the radix digit
// emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_W       = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;
  localparam int STEP_W     = $clog2(VALUE_BITS);
  localparam int PTR_W      = $clog2(VALUE_BITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index taken from paddr[2]
  localparam logic REG_RADIX = 1'b0;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] DEC_LIMIT   = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  CHAR_A      = CHAR_W'(8'h41);

  typedef struct packed {
    logic start;   // begin one division pass
    logic load;    // with start: take a new dividend
  } div_ctrl_t;

  typedef struct packed {
    logic done;     // pass finished, digit valid
    logic nonzero;  // quotient of the pass is not zero
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  typedef struct packed {
    logic full;
    logic one_left;
  } stk_stat_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_LIMIT) c = CHAR_ZERO + CHAR_W'(d);
    else               c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
    return c;
  endfunction

endpackage

// ===== rtl/rde_divider.sv =====
// ----------------------------------------------------------------------------
// rde_divider
// Bit-serial restoring divider: one quotient bit per cycle. The quotient
// stays in place for the next pass.
// ----------------------------------------------------------------------------
module rde_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rde_pkg::div_ctrl_t             ctrl,
  input  logic [rde_pkg::IN_W-1:0]       value,
  input  logic [rde_pkg::RADIX_W-1:0]    radix,
  output rde_pkg::div_stat_t             stat,
  output logic [rde_pkg::RADIX_W-1:0]    digit
);
  import rde_pkg::*;

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  nz_r, nz_nxt;
  logic [RADIX_W:0]      rem_sh;
  logic                  qbit;

  // partial remainder stays below twice the radix, so 7 bits suffice
  assign rem_sh = {rem_r, quo_r[VALUE_BITS-1]};
  assign qbit   = (rem_sh >= {1'b0, radix});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    nz_nxt   = nz_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      if (ctrl.load) quo_nxt = VALUE_BITS'(value);
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
      nz_nxt   = 1'b0;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[VALUE_BITS-2:0], qbit};
      rem_nxt  = qbit ? RADIX_W'(rem_sh - {1'b0, radix}) : rem_sh[RADIX_W-1:0];
      nz_nxt   = nz_r | qbit;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    nz_r  <= nz_nxt;
  end

  assign stat.done    = done_r;
  assign stat.nonzero = nz_r;
  assign digit        = rem_r;

endmodule

// ===== rtl/rde_digit_stack.sv =====
// ----------------------------------------------------------------------------
// rde_digit_stack
// LIFO of digit values: remainders come out least significant first and
// leave most significant first.
// ----------------------------------------------------------------------------
module rde_digit_stack (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rde_pkg::stk_ctrl_t           ctrl,
  input  logic [rde_pkg::RADIX_W-1:0]  push_digit,
  output logic [rde_pkg::RADIX_W-1:0]  top_digit,
  output rde_pkg::stk_stat_t           stat
);
  import rde_pkg::*;

  logic [RADIX_W-1:0] mem_r [VALUE_BITS];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   cnt_dec;

  assign cnt_dec = cnt_r - CNT_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.push)     cnt_nxt = cnt_r + CNT_W'(1);
    else if (ctrl.pop) cnt_nxt = cnt_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
    if (ctrl.push) mem_r[cnt_r[PTR_W-1:0]] <= push_digit;
  end

  assign top_digit     = mem_r[cnt_dec[PTR_W-1:0]];
  assign stat.full     = (cnt_r == CNT_W'(VALUE_BITS));
  assign stat.one_left = (cnt_r == CNT_W'(1));

endmodule

// ===== rtl/radix_digit_emitter_unit.sv =====
// ----------------------------------------------------------------------------
// radix_digit_emitter_unit
// Converts an unsigned value into ASCII digits of a programmable base,
// most significant digit first, with the final digit flagged.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_value) takes one value at a time;
//   in_stall is high from acceptance until the last digit of that value has
//   moved into the output register.
//   Output channel (out_valid/out_stall/out_digit_char/out_last) gives one
//   item per digit; out_last marks the least significant digit. Zero gives
//   a single '0'.
//   The APB port holds the radix register at address 0 (reset 10); values
//   outside 2..36 saturate. Write it only while the block is idle.
// Operation:
//   Each digit costs one pass of the bit-serial divider (one quotient bit
//   per cycle). The digits then leave the digit stack one per cycle while
//   the output does not stall.
// Reset (rst_n, synchronous) empties the block and restores radix 10.
// A stall on the output holds the current item; emission pauses meanwhile.
// ----------------------------------------------------------------------------
module radix_digit_emitter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rde_pkg::IN_W-1:0]            in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rde_pkg::CHAR_W-1:0]          out_digit_char,
  output logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rde_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [rde_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [rde_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import rde_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [RADIX_W-1:0] radix_r;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [RADIX_W-1:0] div_digit;
  stk_ctrl_t          stk_ctrl;
  stk_stat_t          stk_stat;
  logic [RADIX_W-1:0] top_digit;
  logic               in_acc;
  logic               out_free;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIX) ? CFG_DATA_W'(radix_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RADIX)) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  rde_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .value (in_value),
    .radix (eff_radix(radix_r)),
    .stat  (div_stat),
    .digit (div_digit)
  );

  rde_digit_stack u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (stk_ctrl),
    .push_digit (div_digit),
    .top_digit  (top_digit),
    .stat       (stk_stat)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    div_ctrl      = '0;
    stk_ctrl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          div_ctrl.start = 1'b1;
          div_ctrl.load  = 1'b1;
          state_nxt      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          if (div_stat.nonzero) div_ctrl.start = 1'b1;
          else                  state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          stk_ctrl.pop  = 1'b1;
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(top_digit);
          out_last_nxt  = stk_stat.one_left;
          if (stk_stat.one_left) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

  // a pass never produces more digits than the stack holds
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stk_ctrl.push |-> !stk_stat.full)
    else $error("digit stack overflow");

  // an accepted item moves the block into division on the next cycle
  a_acc_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIV))
    else $error("accepted item did not start division");

  // emitted characters always lie in the range '0' to 'Z'
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= CHAR_ZERO) && (out_digit_char <= CHAR_A + CHAR_W'(25)))
    else $error("digit character out of range");

  // the last flag returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (stk_ctrl.pop && stk_stat.one_left) |=> (state_r == ST_IDLE) && out_last)
    else $error("final digit not flagged");

endmodule

// ===== test/tb_radix_digit_emitter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_radix_digit_emitter_unit
// Self-checking bench for the radix digit emitter. Values go in on the input
// channel, every digit item that comes out is checked against a predicted
// digit string for the current radix, and the radix register is written over
// APB (and read back) between phases, including the saturating settings.
// ----------------------------------------------------------------------------
module tb_radix_digit_emitter_unit;
  import rde_pkg::*;

  localparam int WATCHDOG_LIMIT  = 6000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 12;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } digit_item_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [IN_W-1:0]       in_value  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_W-1:0]     out_digit_char;
  logic                  out_last;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [RADIX_W-1:0] radix_reg = RADIX_RESET;
  digit_item_t        pending_digits[$];
  int                 fail_count  = 0;
  bit                 no_idle     = 1'b0;
  int                 out_hold    = 0;
  int                 idle_cycles = 0;

  radix_digit_emitter_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk = ~clk;

  // radix register saturates to 2..36
  function automatic logic [IN_W-1:0] effective_base();
    logic [RADIX_W-1:0] r;
    r = radix_reg;
    if (r < RADIX_MIN) r = RADIX_MIN;
    if (r > RADIX_MAX) r = RADIX_MAX;
    return IN_W'(r);
  endfunction

  // queue the digit string of v, most significant digit first
  task automatic predict_digits(input logic [IN_W-1:0] v);
    logic [IN_W-1:0]    n;
    logic [IN_W-1:0]    base;
    logic [RADIX_W-1:0] digits[VALUE_BITS];
    logic [RADIX_W-1:0] d;
    digit_item_t        it;
    int                 count;
    base  = effective_base();
    n     = v;
    count = 0;
    if (n == '0) begin
      digits[0] = '0;
      count = 1;
    end else begin
      while (n != '0 && count < VALUE_BITS) begin
        digits[count] = RADIX_W'(n % base);
        n = n / base;
        count++;
      end
    end
    for (int k = count - 1; k >= 0; k--) begin
      d = digits[k];
      if (d < DEC_LIMIT) it.digit_char = CHAR_ZERO + CHAR_W'(d);
      else               it.digit_char = CHAR_A + CHAR_W'(d - DEC_LIMIT);
      it.last = (k == 0);
      pending_digits.push_back(it);
    end
  endtask

  function automatic logic [IN_W-1:0] rand_value();
    logic [63:0] p;
    logic [63:0] base;
    int          k;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 100);
      2: begin
        // around a power of the base, where the digit count steps
        base = 64'(effective_base());
        p    = 64'd1;
        k    = $urandom_range(1, 31);
        while (k > 0 && p * base < 64'h1_0000_0000) begin
          p = p * base;
          k--;
        end
        return IN_W'(p - 64'($urandom_range(0, 1)));
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // valid stays high after acceptance unless the next item or a drain lowers it
  task automatic send_value(input logic [IN_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    predict_digits(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of the radix register, then a read back
  task automatic write_radix(input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RADIX, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    radix_reg = data[RADIX_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(radix_reg)) begin
      $error("prdata: expected %0h, actual %0h", CFG_DATA_W'(radix_reg), prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_digits.size() == 0) begin
          $error("unexpected item: digit_char %0h last %0b", out_digit_char, out_last);
          fail_count++;
        end else begin
          digit_item_t exp_item;
          exp_item = pending_digits.pop_front();
          if (out_digit_char !== exp_item.digit_char) begin
            $error("digit_char: expected %0h, actual %0h", exp_item.digit_char,
                   out_digit_char);
            fail_count++;
          end
          if (out_last !== exp_item.last) begin
            $error("last: expected %0b, actual %0b", exp_item.last, out_last);
            fail_count++;
          end
        end
        out_hold = no_idle ? 0 : $urandom_range(0, 3);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic test_default_radix();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1234567890);
    drain();
  endtask

  task automatic test_radix_extremes();
    // base 2 gives the longest strings
    write_radix(32'd2);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    drain();
    write_radix(32'd36);
    send_value(32'd35);
    send_value(32'd36);
    send_value(32'hFFFF_FFFF);
    drain();
    // below range saturates to 2
    write_radix(32'd0);
    send_value(32'd5);
    drain();
    write_radix(32'd1);
    send_value(32'd1);
    drain();
    // above range saturates to 36
    write_radix(32'd37);
    send_value(32'd35);
    drain();
    write_radix(32'd63);
    send_value(32'hFFFF_FFFF);
    drain();
    // upper data bits are dropped, low bits give 16
    write_radix(32'hFFFF_FFD0);
    send_value(32'hDEAD_BEEF);
    send_value(32'd10);
    drain();
  endtask

  task automatic test_random_values();
    logic [CFG_DATA_W-1:0] data;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      data = $urandom;
      if (phase == 0)      data[RADIX_W-1:0] = RADIX_MIN;
      else if (phase == 1) data[RADIX_W-1:0] = RADIX_MAX;
      else if ($urandom_range(0, 1) == 0)
        data[RADIX_W-1:0] = RADIX_W'($urandom_range(2, 36));
      write_radix(data);
      no_idle = (phase == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(rand_value());
      drain();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_radix();
    test_radix_extremes();
    test_random_values();
    if (fail_count == 0 && pending_digits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rde_pkg.sv
rtl/rde_divider.sv
rtl/rde_digit_stack.sv
rtl/radix_digit_emitter_unit.sv
test/tb_radix_digit_emitter_unit.sv
